// ===== rtl/swlt_pkg.sv =====
`timescale 1ns / 1ps

package swlt_pkg;

    localparam int SEQ_W  = 27;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 7;
    localparam int SUM_W  = 64;

    localparam int DEF_TRACK_DEPTH = 128;
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int RESULT_CAP      = 64;

    localparam logic [CNT_W-1:0]  DEF_WINDOW_LIMIT   = 7'd64;
    localparam logic [TIME_W-1:0] DEF_LOSS_TIMEOUT   = 32'd200000;
    localparam logic [SEQ_W-1:0]  DEF_TOTAL_REQUESTS = 27'd1000000;

    localparam logic [1:0] CFG_WINDOW_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_LOSS_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_TOTAL_REQUESTS = 2'd2;

    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;

    localparam logic [2:0] RES_GRANTED  = 3'd0;
    localparam logic [2:0] RES_REFUSED  = 3'd1;
    localparam logic [2:0] RES_ACCEPTED = 3'd2;
    localparam logic [2:0] RES_IGNORED  = 3'd3;
    localparam logic [2:0] RES_LOST     = 3'd4;
    localparam logic [2:0] RES_NONE     = 3'd5;

    localparam logic [1:0] ST_IN_FLIGHT = 2'd1;
    localparam logic [1:0] ST_ANSWERED  = 2'd2;
    localparam logic [1:0] ST_LOST      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND,
        S_RPL_RD,
        S_RPL_EX,
        S_SCN_RD,
        S_SCN_CHK,
        S_ADV_RD,
        S_ADV_CHK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic send;
        logic rpl_read;
        logic rpl_exec;
        logic scan_init;
        logic scan_read;
        logic scan_step;
        logic adv_read;
        logic adv_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       out_free;
        logic       pend_valid;
        logic       scan_more;
        logic       scan_lost;
        logic       adv_more;
        logic       adv_ok;
    } t_sts;

    typedef struct packed {
        logic              last;
        logic              all_resolved;
        logic [SUM_W-1:0]  rtt_total;
        logic [SEQ_W-1:0]  lost_count;
        logic [SEQ_W-1:0]  received_count;
        logic [SEQ_W-1:0]  sent_count;
        logic [CNT_W-1:0]  in_flight;
        logic [TIME_W-1:0] round_trip;
        logic [SEQ_W-1:0]  seq_number;
        logic [2:0]        result_code;
    } t_res;

endpackage

// ===== rtl/swlt_ctrl.sv =====
`timescale 1ns / 1ps

module swlt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  swlt_pkg::t_sts i_sts,
    output swlt_pkg::t_cmd o_cmd
);

    swlt_pkg::t_state r_state;
    swlt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swlt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            swlt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = swlt_pkg::S_SEND;
                end
            end
            swlt_pkg::S_SEND: begin
                case (i_sts.kind)
                    swlt_pkg::KIND_SEND: begin
                        if (i_sts.out_free) begin
                            o_cmd.send = 1'b1;
                            n_state    = swlt_pkg::S_IDLE;
                        end
                    end
                    swlt_pkg::KIND_REPLY: begin
                        o_cmd.rpl_read = 1'b1;
                        n_state        = swlt_pkg::S_RPL_EX;
                    end
                    swlt_pkg::KIND_SCAN: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = swlt_pkg::S_SCN_RD;
                    end
                    default: begin
                        n_state = swlt_pkg::S_IDLE;
                    end
                endcase
            end
            swlt_pkg::S_RPL_RD: begin
                o_cmd.rpl_read = 1'b1;
                n_state        = swlt_pkg::S_RPL_EX;
            end
            swlt_pkg::S_RPL_EX: begin
                if (i_sts.out_free) begin
                    o_cmd.rpl_exec = 1'b1;
                    n_state        = swlt_pkg::S_IDLE;
                end
            end
            swlt_pkg::S_SCN_RD: begin
                if (i_sts.scan_more) begin
                    o_cmd.scan_read = 1'b1;
                    n_state         = swlt_pkg::S_SCN_CHK;
                end else begin
                    n_state = swlt_pkg::S_ADV_RD;
                end
            end
            swlt_pkg::S_SCN_CHK: begin
                if (!(i_sts.scan_lost && i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = swlt_pkg::S_SCN_RD;
                end
            end
            swlt_pkg::S_ADV_RD: begin
                if (i_sts.adv_more) begin
                    o_cmd.adv_read = 1'b1;
                    n_state        = swlt_pkg::S_ADV_CHK;
                end else begin
                    n_state = swlt_pkg::S_FLUSH;
                end
            end
            swlt_pkg::S_ADV_CHK: begin
                if (i_sts.adv_ok) begin
                    o_cmd.adv_step = 1'b1;
                    n_state        = swlt_pkg::S_ADV_RD;
                end else begin
                    n_state = swlt_pkg::S_FLUSH;
                end
            end
            swlt_pkg::S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = swlt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swlt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/swlt_dp.sv =====
`timescale 1ns / 1ps

module swlt_dp #(
    parameter int TRACK_DEPTH = swlt_pkg::DEF_TRACK_DEPTH,
    parameter int MAX_WINDOW  = swlt_pkg::DEF_MAX_WINDOW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_kind,
    input  logic [swlt_pkg::TIME_W-1:0] i_now_time,
    input  logic [swlt_pkg::SEQ_W-1:0]  i_reply_seq,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output swlt_pkg::t_res              o_out,
    input  swlt_pkg::t_cmd              i_cmd,
    output swlt_pkg::t_sts              o_sts
);

    localparam int AW     = $clog2(TRACK_DEPTH);
    localparam int LimCap = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
    localparam logic [swlt_pkg::CNT_W-1:0] LIM_CAP = swlt_pkg::CNT_W'(LimCap);
    localparam logic [swlt_pkg::SEQ_W-1:0] DEPTH_SEQ = swlt_pkg::SEQ_W'(TRACK_DEPTH);
    localparam logic [swlt_pkg::CNT_W-1:0] CAP = swlt_pkg::CNT_W'(swlt_pkg::RESULT_CAP);

    logic [1:0]                  r_stat_mem [TRACK_DEPTH];
    logic [swlt_pkg::TIME_W-1:0] r_time_mem [TRACK_DEPTH];

    logic [swlt_pkg::CNT_W-1:0]  r_win_lim;
    logic [swlt_pkg::TIME_W-1:0] r_timeout;
    logic [swlt_pkg::SEQ_W-1:0]  r_total;

    logic [1:0]                  r_kind;
    logic [swlt_pkg::TIME_W-1:0] r_now;
    logic [swlt_pkg::SEQ_W-1:0]  r_rseq;

    logic [swlt_pkg::SEQ_W-1:0]  r_next, n_next;
    logic [swlt_pkg::SEQ_W-1:0]  r_base, n_base;
    logic [swlt_pkg::CNT_W-1:0]  r_outst, n_outst;
    logic [swlt_pkg::SEQ_W-1:0]  r_resolved, n_resolved;
    logic [swlt_pkg::SEQ_W-1:0]  r_sent, n_sent;
    logic [swlt_pkg::SEQ_W-1:0]  r_recv, n_recv;
    logic [swlt_pkg::SEQ_W-1:0]  r_lost, n_lost;
    logic [swlt_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [swlt_pkg::SEQ_W-1:0]  r_cursor, n_cursor;
    logic [swlt_pkg::CNT_W-1:0]  r_nlost, n_nlost;

    logic [1:0]                  r_rd_stat;
    logic [swlt_pkg::TIME_W-1:0] r_rd_time;

    logic                        r_out_valid;
    swlt_pkg::t_res              r_out;
    logic                        r_pend_valid;
    swlt_pkg::t_res              r_pend;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [1:0]                  wr_stat;
    logic                        wr_time;

    logic [swlt_pkg::CNT_W-1:0]  lim;
    logic                        grant;
    logic                        rpl_ok;
    logic                        lost_hit;
    logic [swlt_pkg::TIME_W-1:0] age;
    logic [swlt_pkg::SUM_W:0]    sum_wide;
    swlt_pkg::t_res              res_new;
    logic                        emit;
    logic                        out_free;
    logic                        out_load;
    swlt_pkg::t_res              out_word;
    swlt_pkg::t_res              pend_word;

    assign lim      = (r_win_lim > LIM_CAP) ? LIM_CAP : r_win_lim;
    assign grant    = (r_outst < lim) && (r_next < r_total) && ((r_next - r_base) < DEPTH_SEQ);
    assign rpl_ok   = (r_rseq < r_total) && (r_rseq >= r_base) && (r_rseq < r_next)
                      && (r_rd_stat == swlt_pkg::ST_IN_FLIGHT);
    assign age      = r_now - r_rd_time;
    assign lost_hit = (r_rd_stat == swlt_pkg::ST_IN_FLIGHT) && (age > r_timeout);
    assign sum_wide = {1'b0, r_sum} + {{(swlt_pkg::SUM_W - swlt_pkg::TIME_W + 1){1'b0}}, age};
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_en    = i_cmd.rpl_read || i_cmd.scan_read || i_cmd.adv_read;

    always_comb begin
        if (i_cmd.rpl_read) begin
            rd_addr = r_rseq[AW-1:0];
        end else if (i_cmd.adv_read) begin
            rd_addr = r_base[AW-1:0];
        end else begin
            rd_addr = r_cursor[AW-1:0];
        end
    end

    always_comb begin
        n_next     = r_next;
        n_base     = r_base;
        n_outst    = r_outst;
        n_resolved = r_resolved;
        n_sent     = r_sent;
        n_recv     = r_recv;
        n_lost     = r_lost;
        n_sum      = r_sum;
        n_cursor   = r_cursor;
        n_nlost    = r_nlost;
        wr_en      = 1'b0;
        wr_addr    = r_next[AW-1:0];
        wr_stat    = swlt_pkg::ST_IN_FLIGHT;
        wr_time    = 1'b0;
        res_new    = '0;
        emit       = 1'b0;

        if (i_cmd.send) begin
            emit = 1'b1;
            if (grant) begin
                wr_en   = 1'b1;
                wr_time = 1'b1;
                n_outst = r_outst + 1'b1;
                n_next  = r_next + 1'b1;
                n_sent  = r_sent + 1'b1;
                res_new.result_code = swlt_pkg::RES_GRANTED;
                res_new.seq_number  = r_next;
            end else begin
                res_new.result_code = swlt_pkg::RES_REFUSED;
            end
        end

        if (i_cmd.rpl_exec) begin
            emit               = 1'b1;
            res_new.seq_number = r_rseq;
            if (rpl_ok) begin
                wr_en      = 1'b1;
                wr_addr    = r_rseq[AW-1:0];
                wr_stat    = swlt_pkg::ST_ANSWERED;
                n_sum      = sum_wide[swlt_pkg::SUM_W] ? '1 : sum_wide[swlt_pkg::SUM_W-1:0];
                n_outst    = (r_outst != '0) ? r_outst - 1'b1 : r_outst;
                n_resolved = r_resolved + 1'b1;
                n_recv     = r_recv + 1'b1;
                res_new.result_code = swlt_pkg::RES_ACCEPTED;
                res_new.round_trip  = age;
            end else begin
                res_new.result_code = swlt_pkg::RES_IGNORED;
            end
        end

        if (i_cmd.scan_init) begin
            n_cursor = r_base;
            n_nlost  = '0;
        end

        if (i_cmd.scan_step) begin
            n_cursor = r_cursor + 1'b1;
            if (lost_hit) begin
                wr_en      = 1'b1;
                wr_addr    = r_cursor[AW-1:0];
                wr_stat    = swlt_pkg::ST_LOST;
                n_outst    = (r_outst != '0) ? r_outst - 1'b1 : r_outst;
                n_resolved = r_resolved + 1'b1;
                n_lost     = r_lost + 1'b1;
                n_nlost    = r_nlost + 1'b1;
                res_new.result_code = swlt_pkg::RES_LOST;
                res_new.seq_number  = r_cursor;
            end
        end

        if (i_cmd.adv_step) begin
            n_base = r_base + 1'b1;
        end

        if (i_cmd.flush) begin
            res_new.result_code = swlt_pkg::RES_NONE;
        end

        res_new.in_flight      = n_outst;
        res_new.sent_count     = n_sent;
        res_new.received_count = n_recv;
        res_new.lost_count     = n_lost;
        res_new.rtt_total      = n_sum;
        res_new.all_resolved   = (n_resolved >= r_total);
        res_new.last           = 1'b1;
    end

    always_comb begin
        pend_word      = r_pend;
        pend_word.last = 1'b0;
        out_load       = 1'b0;
        out_word       = res_new;
        if (emit) begin
            out_load = 1'b1;
        end else if (i_cmd.scan_step && lost_hit && r_pend_valid) begin
            out_load = 1'b1;
            out_word = pend_word;
        end else if (i_cmd.flush) begin
            out_load = 1'b1;
            out_word = r_pend_valid ? r_pend : res_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stat_mem[wr_addr] <= wr_stat;
        end
        if (wr_en && wr_time) begin
            r_time_mem[wr_addr] <= r_now;
        end
        if (rd_en) begin
            r_rd_stat <= r_stat_mem[rd_addr];
            r_rd_time <= r_time_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_now  <= i_now_time;
            r_rseq <= i_reply_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lim <= swlt_pkg::DEF_WINDOW_LIMIT;
            r_timeout <= swlt_pkg::DEF_LOSS_TIMEOUT;
            r_total   <= swlt_pkg::DEF_TOTAL_REQUESTS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swlt_pkg::CFG_WINDOW_LIMIT:   r_win_lim <= i_cfg_data[swlt_pkg::CNT_W-1:0];
                swlt_pkg::CFG_LOSS_TIMEOUT:   r_timeout <= i_cfg_data;
                swlt_pkg::CFG_TOTAL_REQUESTS: r_total   <= i_cfg_data[swlt_pkg::SEQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next       <= '0;
            r_base       <= '0;
            r_outst      <= '0;
            r_resolved   <= '0;
            r_sent       <= '0;
            r_recv       <= '0;
            r_lost       <= '0;
            r_sum        <= '0;
            r_cursor     <= '0;
            r_nlost      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_next     <= n_next;
            r_base     <= n_base;
            r_outst    <= n_outst;
            r_resolved <= n_resolved;
            r_sent     <= n_sent;
            r_recv     <= n_recv;
            r_lost     <= n_lost;
            r_sum      <= n_sum;
            r_cursor   <= n_cursor;
            r_nlost    <= n_nlost;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.scan_init) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.scan_step && lost_hit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_word;
        end
        if (i_cmd.scan_step && lost_hit) begin
            r_pend <= res_new;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;
    assign o_sts.kind       = r_kind;
    assign o_sts.out_free   = out_free;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.scan_more  = (r_cursor < r_next) && (r_nlost < CAP);
    assign o_sts.scan_lost  = lost_hit;
    assign o_sts.adv_more   = (r_base < r_next) && (r_base < r_total);
    assign o_sts.adv_ok     = (r_rd_stat == swlt_pkg::ST_ANSWERED)
                              || (r_rd_stat == swlt_pkg::ST_LOST);

endmodule

// ===== rtl/sliding_window_loss_tracker.sv =====
`timescale 1ns / 1ps

// Sender-side request window tracker. Each input word is a send request, a reply or a
// timeout scan, selected by tuser. A send puts its result into the output register once
// that register is free; a reply first reads its ring entry, then does the same. A scan
// reads and then checks each tracking ring entry from the window base to the next
// sequence number, emits one lost result per expired entry (at most 64), then walks the
// base forward over resolved entries, reading and checking each, and ends with a final
// result; the single-port ring read sets the pace of both walks. A new input word is
// taken only after the previous one has finished, but the output register lets it be
// taken while the last result still waits. TRACK_DEPTH must be a power of two.

module sliding_window_loss_tracker #(
    parameter int TRACK_DEPTH = swlt_pkg::DEF_TRACK_DEPTH,
    parameter int MAX_WINDOW  = swlt_pkg::DEF_MAX_WINDOW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,  // now_time, reply_seq, zero fill
    input  logic [1:0]   i_s_axis_tuser,  // kind
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_code, seq_number, round_trip, in_flight, sent_count, received_count,
    // lost_count, rtt_total, all_resolved, zero fill
    output logic [215:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    swlt_pkg::t_cmd cmd;
    swlt_pkg::t_sts sts;
    swlt_pkg::t_res res;
    logic           in_ready;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = in_ready;

    swlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swlt_dp #(
        .TRACK_DEPTH (TRACK_DEPTH),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_s_axis_tuser),
        .i_now_time  (i_s_axis_tdata[31:0]),
        .i_reply_seq (i_s_axis_tdata[58:32]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (res),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign o_m_axis_tdata = {1'b0, res.all_resolved, res.rtt_total, res.lost_count,
                             res.received_count, res.sent_count, res.in_flight,
                             res.round_trip, res.seq_number, res.result_code};
    assign o_m_axis_tlast = res.last;

endmodule
